// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

// ===== src/ed_pkg.sv =====
// Types and constants for the equirectangular distance pipeline.
// No dependencies.
package ed_pkg;

    localparam int XW = 34;
    localparam int VW = 36;

    localparam logic [27:0] DEG90_Q20  = 28'd94371840;
    localparam logic [27:0] DEG180_Q20 = 28'd188743680;
    localparam logic [34:0] DEG2RAD_Q40 = 35'd19190098069;
    localparam logic [17:0] DEG2RAD_LO = DEG2RAD_Q40[17:0];
    localparam logic [16:0] DEG2RAD_HI = DEG2RAD_Q40[34:18];
    localparam logic [XW-1:0] INV_GAIN_Q30 = XW'(652032874);
    localparam logic [29:0] MILES_Q24 = 30'd703449741;
    localparam logic [22:0] OUT_MAX = 23'd8388607;

    localparam logic [29:0] ATAN_Q30 [32] = '{
        30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6,
        30'h03FEAB76, 30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55,
        30'h003FFFEA, 30'h001FFFFD, 30'h000FFFFF, 30'h0007FFFF,
        30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF, 30'h00007FFF,
        30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
        30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F,
        30'h0000003F, 30'h0000001F, 30'h0000000F, 30'h00000007,
        30'h00000003, 30'h00000001, 30'h00000000, 30'h00000000
    };

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [XW-1:0] z;
        logic [29:0]          adlon;
        logic [28:0]          dy;
    } rot_t;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
    } vec_t;

endpackage

// ===== src/ed_rot_cell.sv =====
// One rotation-mode CORDIC step of the cosine chain.
// Depends on ed_pkg.
module ed_rot_cell #(
    parameter int SHIFT = 0
) (
    input  logic          clk,
    input  logic          en,
    input  ed_pkg::rot_t  d_in,
    output ed_pkg::rot_t  d_out
);

    localparam logic signed [ed_pkg::XW-1:0] ANG =
        ed_pkg::XW'(ed_pkg::ATAN_Q30[SHIFT]);

    ed_pkg::rot_t d_reg;
    ed_pkg::rot_t d_next;
    logic signed [ed_pkg::XW-1:0] xs;
    logic signed [ed_pkg::XW-1:0] ys;

    always_comb
    begin
        xs = d_in.x >>> SHIFT;
        ys = d_in.y >>> SHIFT;
        d_next = d_in;
        if (!d_in.z[ed_pkg::XW-1])
        begin
            d_next.x = d_in.x - ys;
            d_next.y = d_in.y + xs;
            d_next.z = d_in.z - ANG;
        end
        else
        begin
            d_next.x = d_in.x + ys;
            d_next.y = d_in.y - xs;
            d_next.z = d_in.z + ANG;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

// ===== src/ed_vec_cell.sv =====
// One vectoring-mode CORDIC step of the magnitude chain.
// Depends on ed_pkg.
module ed_vec_cell #(
    parameter int SHIFT = 0
) (
    input  logic          clk,
    input  logic          en,
    input  ed_pkg::vec_t  d_in,
    output ed_pkg::vec_t  d_out
);

    ed_pkg::vec_t d_reg;
    ed_pkg::vec_t d_next;
    logic signed [ed_pkg::VW-1:0] xs;
    logic signed [ed_pkg::VW-1:0] ys;

    always_comb
    begin
        xs = d_in.x >>> SHIFT;
        ys = d_in.y >>> SHIFT;
        if (!d_in.y[ed_pkg::VW-1])
        begin
            d_next.x = d_in.x + ys;
            d_next.y = d_in.y - xs;
        end
        else
        begin
            d_next.x = d_in.x - ys;
            d_next.y = d_in.y + xs;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

// ===== src/equirectangular_distance.sv =====
// Channel   Valid        Stall        Payload
// pair      pair_valid   pair_stall   lat_a, lon_a, lat_b, lon_b
// dist      dist_valid   dist_stall   distance_miles
//
// One point pair is taken per cycle while pair_stall is low; the pipeline holds the input
// stages, the two chains of CORDIC cells, the split multiplies and the output register.
// Reset clears all stage valid bits; payload registers are not reset.
// A stall on the result side fills empty stages before the pair side is stalled.
// Depends on ed_pkg, ed_rot_cell and ed_vec_cell.
module equirectangular_distance #(
    parameter int ITERATIONS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pair_valid,
    output logic               pair_stall,
    input  logic signed [27:0] lat_a,
    input  logic signed [28:0] lon_a,
    input  logic signed [27:0] lat_b,
    input  logic signed [28:0] lon_b,
    output logic               dist_valid,
    input  logic               dist_stall,
    output logic [22:0]        distance_miles
);

    localparam int NS = 2 * ITERATIONS + 8;
    localparam int S_COS = 3;
    localparam int S_CLAMP = 3 + ITERATIONS;
    localparam int S_MUL = 4 + ITERATIONS;
    localparam int S_VEC = 5 + ITERATIONS;
    localparam int S_SPLIT = 5 + 2 * ITERATIONS;
    localparam int S_PROD = 6 + 2 * ITERATIONS;
    localparam int S_OUT = 7 + 2 * ITERATIONS;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;
    logic [NS:0]   en;

    assign en[NS] = !dist_stall;

    for (genvar k = 0; k < NS; k++)
    begin : g_en
        assign en[k] = !vld_reg[k] || en[k+1];
    end

    assign vld_next = {vld_reg[NS-2:0], pair_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    assign pair_stall = !en[0];
    assign dist_valid = vld_reg[NS-1];

    logic signed [29:0] dlon;
    logic signed [28:0] dlat;
    logic [27:0] lat_abs;
    logic [26:0] a_red;

    always_comb
    begin
        dlon = 30'(lon_a) - 30'(lon_b);
        dlat = 29'(lat_a) - 29'(lat_b);
        lat_abs = lat_a[27] ? 28'(-lat_a) : 28'(lat_a);
        a_red = (lat_abs > ed_pkg::DEG90_Q20) ? 27'(ed_pkg::DEG180_Q20 - lat_abs)
                                              : lat_abs[26:0];
    end

    logic [26:0] a_reg;
    logic [29:0] adlon0_reg;
    logic [28:0] dy0_reg;
    logic [44:0] zpl_reg;
    logic [43:0] zph_reg;
    logic [29:0] adlon1_reg;
    logic [28:0] dy1_reg;
    logic [31:0] z_reg;
    logic [29:0] adlon2_reg;
    logic [28:0] dy2_reg;
    logic [61:0] zsum;

    assign zsum = {zph_reg, 18'd0} + 62'(zpl_reg) + 62'(64'd1 << 29);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            a_reg      <= a_red;
            adlon0_reg <= dlon[29] ? 30'(-dlon) : 30'(dlon);
            dy0_reg    <= dlat[28] ? 29'(-dlat) : 29'(dlat);
        end
        if (en[1])
        begin
            zpl_reg    <= 45'(a_reg) * 45'(ed_pkg::DEG2RAD_LO);
            zph_reg    <= 44'(a_reg) * 44'(ed_pkg::DEG2RAD_HI);
            adlon1_reg <= adlon0_reg;
            dy1_reg    <= dy0_reg;
        end
        if (en[2])
        begin
            z_reg      <= zsum[61:30];
            adlon2_reg <= adlon1_reg;
            dy2_reg    <= dy1_reg;
        end
    end

    ed_pkg::rot_t rot_s [ITERATIONS+1];

    always_comb
    begin
        rot_s[0].x     = ed_pkg::INV_GAIN_Q30;
        rot_s[0].y     = '0;
        rot_s[0].z     = ed_pkg::XW'(z_reg);
        rot_s[0].adlon = adlon2_reg;
        rot_s[0].dy    = dy2_reg;
    end

    for (genvar i = 0; i < ITERATIONS; i++)
    begin : g_rot
        ed_rot_cell #(
            .SHIFT(i)
        ) u_cell (
            .clk  (clk),
            .en   (en[S_COS+i]),
            .d_in (rot_s[i]),
            .d_out(rot_s[i+1])
        );
    end

    logic [30:0] c_reg;
    logic [29:0] adlon3_reg;
    logic [28:0] dy3_reg;
    logic [30:0] c_next;
    logic [60:0] p_reg;
    logic [28:0] dy4_reg;

    always_comb
    begin
        if (rot_s[ITERATIONS].x[ed_pkg::XW-1])
        begin
            c_next = '0;
        end
        else if (rot_s[ITERATIONS].x > ed_pkg::XW'(64'd1 << 30))
        begin
            c_next = 31'(64'd1 << 30);
        end
        else
        begin
            c_next = rot_s[ITERATIONS].x[30:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[S_CLAMP])
        begin
            c_reg      <= c_next;
            adlon3_reg <= rot_s[ITERATIONS].adlon;
            dy3_reg    <= rot_s[ITERATIONS].dy;
        end
        if (en[S_MUL])
        begin
            p_reg   <= 61'(adlon3_reg) * 61'(c_reg);
            dy4_reg <= dy3_reg;
        end
    end

    logic [61:0] dxsum;
    ed_pkg::vec_t vec_s [ITERATIONS+1];

    assign dxsum = 62'(p_reg) + 62'(64'd1 << 29);

    always_comb
    begin
        vec_s[0].x = ed_pkg::VW'({dxsum[61:30], 2'b00});
        vec_s[0].y = ed_pkg::VW'({dy4_reg, 2'b00});
    end

    for (genvar i = 0; i < ITERATIONS; i++)
    begin : g_vec
        ed_vec_cell #(
            .SHIFT(i)
        ) u_cell (
            .clk  (clk),
            .en   (en[S_VEC+i]),
            .d_in (vec_s[i]),
            .d_out(vec_s[i+1])
        );
    end

    logic [34:0] mag_reg;
    logic [47:0] mpl_reg;
    logic [46:0] mph_reg;
    logic [65:0] msum;
    logic [27:0] dist_raw;
    logic [22:0] dist_reg;

    assign msum = {1'b0, mph_reg, 18'd0} + 66'(mpl_reg) + 66'(66'd1 << 37);
    assign dist_raw = msum[65:38];

    always_ff @(posedge clk)
    begin
        if (en[S_SPLIT])
        begin
            mag_reg <= vec_s[ITERATIONS].x[ed_pkg::VW-1] ? '0
                                                         : vec_s[ITERATIONS].x[34:0];
        end
        if (en[S_PROD])
        begin
            mpl_reg <= 48'(mag_reg[17:0]) * 48'(ed_pkg::MILES_Q24);
            mph_reg <= 47'(mag_reg[34:18]) * 47'(ed_pkg::MILES_Q24);
        end
        if (en[S_OUT])
        begin
            dist_reg <= (dist_raw > 28'(ed_pkg::OUT_MAX)) ? ed_pkg::OUT_MAX
                                                          : dist_raw[22:0];
        end
    end

    assign distance_miles = dist_reg;

endmodule

// ===== src/ed_check.sv =====
// Port-level checker for equirectangular_distance, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module ed_check (
    input logic        clk,
    input logic        rst_n,
    input logic        pair_stall,
    input logic        dist_valid,
    input logic        dist_stall,
    input logic [22:0] distance_miles
);

    // An empty output stage means every stage can move, so pairs are never held off.
    `ASSERT_IMPLIES(a_idle_out_takes, clk, rst_n, !dist_valid, !pair_stall)
    // With the result side free the whole pipeline advances.
    `ASSERT_IMPLIES(a_free_out_takes, clk, rst_n, !dist_stall, !pair_stall)
    // A stalled result stays valid.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, dist_valid && dist_stall, dist_valid)
    // A stalled result keeps its value.
    `ASSERT_NEXT(a_out_stable, clk, rst_n, dist_valid && dist_stall,
        $stable(distance_miles))

endmodule

bind equirectangular_distance ed_check u_ed_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .pair_stall    (pair_stall),
    .dist_valid    (dist_valid),
    .dist_stall    (dist_stall),
    .distance_miles(distance_miles)
);
